// ===== hdl/interval_bit_error_checker_core_defines.svh =====
// assertion macros for the interval bit error checker
`ifndef INTERVAL_BIT_ERROR_CHECKER_CORE_DEFINES_SVH
`define INTERVAL_BIT_ERROR_CHECKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IBE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IBE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/ibe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_pkg
// shared types and constants of the interval bit error checker
// ----------------------------------------------------------------------------
package ibe_pkg;
  localparam int INTERVAL_BITS = 2048;
  localparam int PROBE_BITS    = 256;
  localparam int POS_W         = 11;
  localparam int ORD_W         = 17;
  localparam int CAND_W        = 18;
  localparam int CNT_W         = 12;
  localparam int ERR_W         = 9;

  localparam logic [ORD_W-1:0] ORDINAL_MAX = 17'h1FFFF;
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic [ERR_W-1:0] ERR_INIT   = 9'd257;
  localparam logic [ERR_W-1:0] BEST_LIMIT = 9'd64;
  localparam logic [ERR_W:0]   GAP_MIN    = 10'd32;
  localparam logic [CAND_W-1:0] LOOK_BACK = 18'd16;
  localparam logic [CAND_W-1:0] LOOK_FWD  = 18'd65;

  localparam logic [63:0] SEED_RESET  = 64'd417;
  localparam logic [ORD_W-1:0] ICNT_RESET = 17'd100;

  localparam logic [0:0] CFG_SEED = 1'b0;
  localparam logic [0:0] CFG_ICNT = 1'b1;

  // code bits: [1] erased, [0] one
  typedef struct packed {
    logic [1:0]       code;
    logic [POS_W-1:0] pos;
    logic [ORD_W-1:0] rx;
    logic             last;
  } item_t;
endpackage

// ===== hdl/ibe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_front
// accepts soft bits, classifies the sign and tags position and interval
// ----------------------------------------------------------------------------
module ibe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_soft_sample,
  input  logic                q_full,
  output logic                q_push,
  output ibe_pkg::item_t      q_item
);
  logic [ibe_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [ibe_pkg::ORD_W-1:0] rx_r, rx_nxt;
  logic last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign last     = (pos_r == ibe_pkg::POS_W'(ibe_pkg::INTERVAL_BITS - 1));

  always_comb begin
    q_item.code[1] = (in_soft_sample == 16'sd0);
    q_item.code[0] = (in_soft_sample != 16'sd0) && !in_soft_sample[15];
    q_item.pos     = pos_r;
    q_item.rx      = rx_r;
    q_item.last    = last;
    pos_nxt = pos_r;
    rx_nxt  = rx_r;
    if (q_push) begin
      pos_nxt = last ? '0 : pos_r + 1'b1;
      if (last && rx_r != ibe_pkg::ORDINAL_MAX) begin
        rx_nxt = rx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rx_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      rx_r  <= rx_nxt;
    end
  end
endmodule

// ===== hdl/ibe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module ibe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ibe_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ibe_pkg::item_t q_item
);
  ibe_pkg::item_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    if (push) begin
      wr_nxt = ~wr_r;
    end
    if (do_pop) begin
      rd_nxt = ~rd_r;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end
endmodule

// ===== hdl/ibe_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_mul64
// low 64 bits of a 64x64 product, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module ibe_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  logic [63:0] a_r, b_r, prod_r, lo_r, p_r;
  logic [31:0] mid_r;
  logic [31:0] ma, mb;
  logic [2:0]  step_r;
  logic        busy_r, done_r;

  assign done = done_r;
  assign p    = p_r;

  always_comb begin
    unique case (step_r)
      3'd0:    begin ma = a_r[31:0];  mb = b_r[31:0];  end
      3'd1:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      default: begin ma = a_r[63:32]; mb = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) begin
      unique case (step_r)
        3'd1:    lo_r  <= prod_r;
        3'd2:    mid_r <= prod_r[31:0];
        3'd3:    p_r   <= lo_r + {mid_r + prod_r[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/ibe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_back
// counts errors, buffers the interval, searches candidates and recounts
// ----------------------------------------------------------------------------
module ibe_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [63:0]                      pattern_seed,
  input  logic [ibe_pkg::ORD_W-1:0]        interval_count,
  input  logic                             q_valid,
  input  ibe_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ibe_pkg::ORD_W-1:0]        out_interval_number,
  output logic [ibe_pkg::CNT_W-1:0]        out_wrong_bits,
  output logic [ibe_pkg::CNT_W-1:0]        out_erased_bits,
  output logic                             out_interval_exact,
  output logic                             out_alignable,
  output logic signed [7:0]                out_align_offset,
  output logic [ibe_pkg::CNT_W-1:0]        out_align_wrong_bits,
  output logic [ibe_pkg::CNT_W-1:0]        out_align_erased_bits
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_COUNT, ST_H_M0, ST_H_W0, ST_H_M1, ST_H_W1, ST_H_M2, ST_H_W2,
    ST_SETUP, ST_RD, ST_CMP, ST_EVAL, ST_DECIDE, ST_FINISH
  } state_t;

  state_t state_r, ret_r;
  logic [1:0] mem [ibe_pkg::INTERVAL_BITS];
  logic [1:0] rd_r;
  logic [63:0] idx_r, hx_r;
  logic [7:0]  refbyte_r;
  logic [ibe_pkg::CNT_W-1:0] wrong_r, erased_r, awrong_r, aerased_r;
  logic [ibe_pkg::ORD_W-1:0] rx_r;
  logic [ibe_pkg::CAND_W-1:0] cand_r, upper_r, best_ord_r;
  logic [ibe_pkg::POS_W-1:0] i_r;
  logic [ibe_pkg::ERR_W-1:0] errs_r, best_r, second_r;
  logic phase_r, ok_r;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic [ibe_pkg::CAND_W-1:0] rx_ext, lower, upper;
  logic [ibe_pkg::POS_W-1:0] i_inc;
  logic        q_bit, s_bit, mism, ok;
  logic [ibe_pkg::ERR_W:0] best_gap;

  ibe_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a     = hx_r;
    mul_b     = ibe_pkg::MIX_C1;
    unique case (state_r)
      ST_H_M0: begin mul_start = 1'b1; mul_a = pattern_seed; mul_b = ibe_pkg::GOLDEN; end
      ST_H_M1: begin mul_start = 1'b1; end
      ST_H_M2: begin mul_start = 1'b1; mul_b = ibe_pkg::MIX_C2; end
      default: ;
    endcase
  end

  assign q_pop  = (state_r == ST_COUNT);
  assign rx_ext = {1'b0, rx_r};
  assign lower  = (rx_ext > ibe_pkg::LOOK_BACK) ? rx_ext - ibe_pkg::LOOK_BACK : '0;
  assign upper  = ({1'b0, interval_count} < rx_ext + ibe_pkg::LOOK_FWD) ?
                  {1'b0, interval_count} : rx_ext + ibe_pkg::LOOK_FWD;
  assign i_inc  = i_r + 1'b1;
  assign q_bit  = refbyte_r[~q_item.pos[2:0]];
  assign s_bit  = refbyte_r[~i_r[2:0]];
  assign mism   = rd_r[0] != s_bit;
  assign best_gap = {1'b0, best_r} + ibe_pkg::GAP_MIN;
  assign ok     = (best_r < ibe_pkg::BEST_LIMIT) && ({1'b0, second_r} > best_gap);

  always_ff @(posedge clk) begin
    if (state_r == ST_COUNT) begin
      mem[q_item.pos] <= q_item.code;
    end
    rd_r <= mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_r     <= ST_IDLE;
      wrong_r   <= '0;
      erased_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state_r == ST_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.pos[2:0] == 3'd0) begin
              idx_r   <= {39'd0, q_item.rx, q_item.pos[10:3]};
              ret_r   <= ST_COUNT;
              state_r <= ST_H_M0;
            end else begin
              state_r <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          if (q_item.code[1]) begin
            erased_r <= erased_r + 1'b1;
          end else if (q_item.rx >= interval_count || q_item.code[0] != q_bit) begin
            wrong_r <= wrong_r + 1'b1;
          end
          if (q_item.last) begin
            rx_r    <= q_item.rx;
            state_r <= ST_SETUP;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_H_M0: state_r <= ST_H_W0;
        ST_H_W0: begin
          if (mul_done) begin
            hx_r    <= (mul_p + idx_r) ^ ((mul_p + idx_r) >> 30);
            state_r <= ST_H_M1;
          end
        end
        ST_H_M1: state_r <= ST_H_W1;
        ST_H_W1: begin
          if (mul_done) begin
            hx_r    <= mul_p ^ (mul_p >> 27);
            state_r <= ST_H_M2;
          end
        end
        ST_H_M2: state_r <= ST_H_W2;
        ST_H_W2: begin
          if (mul_done) begin
            refbyte_r <= mul_p[7:0] ^ mul_p[38:31];
            state_r   <= ret_r;
          end
        end
        ST_SETUP: begin
          cand_r   <= lower;
          upper_r  <= upper;
          best_r   <= ibe_pkg::ERR_INIT;
          second_r <= ibe_pkg::ERR_INIT;
          best_ord_r <= '0;
          phase_r  <= 1'b0;
          i_r      <= '0;
          errs_r   <= '0;
          if (lower >= upper) begin
            state_r <= ST_DECIDE;
          end else begin
            idx_r   <= {38'd0, lower, 8'd0};
            ret_r   <= ST_RD;
            state_r <= ST_H_M0;
          end
        end
        ST_RD: state_r <= ST_CMP;
        ST_CMP: begin
          if (!phase_r) begin
            if (rd_r[1] || mism) begin
              errs_r <= errs_r + 1'b1;
            end
          end else if (rd_r[1]) begin
            aerased_r <= aerased_r + 1'b1;
          end else if (mism) begin
            awrong_r <= awrong_r + 1'b1;
          end
          if (!phase_r && i_r == ibe_pkg::POS_W'(ibe_pkg::PROBE_BITS - 1)) begin
            state_r <= ST_EVAL;
          end else if (phase_r && i_r == ibe_pkg::POS_W'(ibe_pkg::INTERVAL_BITS - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            i_r <= i_inc;
            if (i_inc[2:0] == 3'd0) begin
              idx_r   <= {38'd0, cand_r, i_inc[10:3]};
              ret_r   <= ST_RD;
              state_r <= ST_H_M0;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_EVAL: begin
          if (errs_r < best_r) begin
            second_r   <= best_r;
            best_r     <= errs_r;
            best_ord_r <= cand_r;
          end else if (errs_r < second_r) begin
            second_r <= errs_r;
          end
          if (cand_r + 1'b1 >= upper_r) begin
            state_r <= ST_DECIDE;
          end else begin
            cand_r  <= cand_r + 1'b1;
            i_r     <= '0;
            errs_r  <= '0;
            idx_r   <= {38'd0, cand_r + 1'b1, 8'd0};
            ret_r   <= ST_RD;
            state_r <= ST_H_M0;
          end
        end
        ST_DECIDE: begin
          ok_r      <= ok;
          awrong_r  <= '0;
          aerased_r <= '0;
          if (ok) begin
            phase_r <= 1'b1;
            i_r     <= '0;
            cand_r  <= best_ord_r;
            idx_r   <= {38'd0, best_ord_r, 8'd0};
            ret_r   <= ST_RD;
            state_r <= ST_H_M0;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_interval_number   <= rx_r;
            out_wrong_bits        <= wrong_r;
            out_erased_bits       <= erased_r;
            out_interval_exact    <= (wrong_r == '0) && (erased_r == '0);
            out_alignable         <= ok_r;
            out_align_offset      <= ok_r ? 8'(best_ord_r - rx_ext) : 8'sd0;
            out_align_wrong_bits  <= awrong_r;
            out_align_erased_bits <= aerased_r;
            wrong_r  <= '0;
            erased_r <= '0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/interval_bit_error_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_bit_error_checker_core
// bit error checker over fixed 2048-bit intervals with alignment search
// ----------------------------------------------------------------------------
// Each soft bit is taken into a two-word queue and passes the back end through
// its idle and count states; every eighth word (a new reference byte) adds one
// splitmix64 hash, three 64-bit multiplies on one shared 32x32 multiplier.
// After the last word of an interval the back end runs the candidate search:
// up to 81 candidates, each 32 hashes plus 256 compares (a read state, then a
// compare state), then a 2048-bit recount when alignable; words are held off
// by ready during that time. The result waits in an output register.
`include "interval_bit_error_checker_core_defines.svh"
module interval_bit_error_checker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_soft_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ibe_pkg::ORD_W-1:0]        out_interval_number,
  output logic [ibe_pkg::CNT_W-1:0]        out_wrong_bits,
  output logic [ibe_pkg::CNT_W-1:0]        out_erased_bits,
  output logic                             out_interval_exact,
  output logic                             out_alignable,
  output logic signed [7:0]                out_align_offset,
  output logic [ibe_pkg::CNT_W-1:0]        out_align_wrong_bits,
  output logic [ibe_pkg::CNT_W-1:0]        out_align_erased_bits,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [63:0]                      cfg_data
);
  logic [63:0] seed_r;
  logic [ibe_pkg::ORD_W-1:0] icnt_r;
  logic q_full, q_push, q_pop, q_valid;
  ibe_pkg::item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= ibe_pkg::SEED_RESET;
      icnt_r <= ibe_pkg::ICNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ibe_pkg::CFG_SEED: seed_r <= cfg_data;
        ibe_pkg::CFG_ICNT: icnt_r <= cfg_data[ibe_pkg::ORD_W-1:0];
        default: ;
      endcase
    end
  end

  ibe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_soft_sample (in_soft_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  ibe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ibe_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pattern_seed          (seed_r),
    .interval_count        (icnt_r),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_interval_number   (out_interval_number),
    .out_wrong_bits        (out_wrong_bits),
    .out_erased_bits       (out_erased_bits),
    .out_interval_exact    (out_interval_exact),
    .out_alignable         (out_alignable),
    .out_align_offset      (out_align_offset),
    .out_align_wrong_bits  (out_align_wrong_bits),
    .out_align_erased_bits (out_align_erased_bits)
  );

  `IBE_ASSERT_IMP(a_exact, clk, rst_n, out_valid, out_interval_exact == ((out_wrong_bits == '0) && (out_erased_bits == '0)))
  `IBE_ASSERT_IMP(a_noalign, clk, rst_n, out_valid && !out_alignable, (out_align_offset == 8'sd0) && (out_align_wrong_bits == '0) && (out_align_erased_bits == '0))
  `IBE_ASSERT_IMP(a_offset, clk, rst_n, out_valid && out_alignable, (out_align_offset >= -8'sd16) && (out_align_offset <= 8'sd64))
  `IBE_ASSERT_NXT(a_pop, clk, rst_n, q_pop && q_valid && q_item.last, !q_pop)
endmodule
